[src/utfl_pkg.sv]
package utfl_pkg;

  localparam int GLYPH_SLOTS_DEF      = 4096;
  localparam int ATLAS_COORD_BITS_DEF = 11;
  localparam int POSITION_BITS_DEF    = 16;
  localparam int PAGE_COUNT_DEF       = 4;

  localparam int CODE_W = 21;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  // UTF-8 lead byte tags
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 21'd10;

  typedef enum logic [1:0] {
    K_NONE    = 2'd0,
    K_START   = 2'd1,
    K_NEWLINE = 2'd2,
    K_GLYPH   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] origin_xy;
  } item_ctl_t;

  // entry: present, ax, ay, w, h, ox, oy, adv, page
  function automatic int entry_w(input int acb);
    return 2 * acb + 38;
  endfunction

endpackage

[src/utf8_text_glyph_layout.sv]
// A drawn glyph's blit beat is registered: its last text byte is taken into the store read stage,
// whose result the cursor stage loads into the output register once that is free. Throughput: one
// request per cycle while in_ready is high; the glyph store has one read and one write port, and the
// cursor update sits in the stage after the store read. Reset: synchronous; afterwards a sweep marks
// every store entry absent, with in_ready low. The line height register is writable throughout.
module utf8_text_glyph_layout #(
  parameter int GLYPH_SLOTS      = utfl_pkg::GLYPH_SLOTS_DEF,
  parameter int ATLAS_COORD_BITS = utfl_pkg::ATLAS_COORD_BITS_DEF,
  parameter int POSITION_BITS    = utfl_pkg::POSITION_BITS_DEF,
  parameter int PAGE_COUNT       = utfl_pkg::PAGE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [11:0]        glyph_code,
  input  logic [10:0]        atlas_x,
  input  logic [10:0]        atlas_y,
  input  logic [6:0]         glyph_w,
  input  logic [6:0]         glyph_h,
  input  logic signed [6:0]  offset_x,
  input  logic signed [6:0]  offset_y,
  input  logic [6:0]         advance,
  input  logic [1:0]         page,
  input  logic [7:0]         text_byte,
  input  logic [31:0]        origin_xy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        src_x,
  output logic [10:0]        src_y,
  output logic [6:0]         blit_w,
  output logic [6:0]         blit_h,
  output logic signed [15:0] dst_x,
  output logic signed [15:0] dst_y,
  output logic [1:0]         atlas_page,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         line_height
);
  import utfl_pkg::*;

  localparam int AW      = $clog2(GLYPH_SLOTS);
  localparam int ACB     = ATLAS_COORD_BITS;
  localparam int ENTRY_W = entry_w(ACB);

  logic              accept;
  logic              clearing;
  logic              stage_free;
  logic [7:0]        line_height_q;
  kind_t             dec_kind;
  logic [CODE_W-1:0] dec_code;
  item_ctl_t         ctl_in;
  logic              wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  assign in_ready  = !clearing && stage_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_height_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      line_height_q <= line_height;
    end
  end

  assign wr_en = accept && (req_type == REQ_WRITE)
              && (32'(glyph_code) < 32'(GLYPH_SLOTS))
              && (32'(page) < 32'(PAGE_COUNT));
  assign wr_data = {1'b1, ACB'(atlas_x), ACB'(atlas_y), glyph_w, glyph_h,
                    offset_x, offset_y, advance, page};

  assign ctl_in.kind      = dec_kind;
  assign ctl_in.origin_xy = origin_xy;

  utfl_decoder #(
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .text_byte (text_byte),
    .kind      (dec_kind),
    .code      (dec_code)
  );

  utfl_glyph_mem #(
    .SLOTS   (GLYPH_SLOTS),
    .ENTRY_W (ENTRY_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (AW'(glyph_code)),
    .wr_data  (wr_data),
    .rd_en    (accept && (dec_kind == K_GLYPH)),
    .rd_addr  (dec_code[AW-1:0]),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  utfl_cursor #(
    .POSITION_BITS    (POSITION_BITS),
    .ATLAS_COORD_BITS (ATLAS_COORD_BITS)
  ) u_cur (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ctl_in      (ctl_in),
    .rd_data     (rd_data),
    .line_height (line_height_q),
    .stage_free  (stage_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .src_x       (src_x),
    .src_y       (src_y),
    .blit_w      (blit_w),
    .blit_h      (blit_h),
    .dst_x       (dst_x),
    .dst_y       (dst_y),
    .atlas_page  (atlas_page)
  );

endmodule

[src/utfl_decoder.sv]
module utfl_decoder #(
  parameter int GLYPH_SLOTS = utfl_pkg::GLYPH_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  text_byte,
  output utfl_pkg::kind_t             kind,
  output logic [utfl_pkg::CODE_W-1:0] code
);
  import utfl_pkg::*;

  logic [CODE_W-1:0] partial_code, partial_code_next;
  logic [1:0]        bytes_pending, bytes_pending_next;
  logic [CODE_W-1:0] cp;
  logic              emit;

  always_comb begin
    partial_code_next  = partial_code;
    bytes_pending_next = bytes_pending;
    cp                 = '0;
    emit               = 1'b0;
    kind               = K_NONE;
    unique case (req_type)
      REQ_START: begin
        kind               = K_START;
        partial_code_next  = '0;
        bytes_pending_next = '0;
      end
      REQ_TEXT: begin
        if (bytes_pending != 2'd0) begin
          // continuation taken unchecked
          cp                 = {partial_code[CODE_W-7:0], text_byte[5:0]};
          partial_code_next  = cp;
          bytes_pending_next = bytes_pending - 2'd1;
          emit               = (bytes_pending == 2'd1);
        end else if (!text_byte[7]) begin
          cp   = {{(CODE_W-8){1'b0}}, text_byte};
          emit = 1'b1;
        end else if (text_byte[7:5] == LEAD2_TAG) begin
          partial_code_next  = {{(CODE_W-5){1'b0}}, text_byte[4:0]};
          bytes_pending_next = 2'd1;
        end else if (text_byte[7:4] == LEAD3_TAG) begin
          partial_code_next  = {{(CODE_W-4){1'b0}}, text_byte[3:0]};
          bytes_pending_next = 2'd2;
        end else if (text_byte[7:3] == LEAD4_TAG) begin
          partial_code_next  = {{(CODE_W-3){1'b0}}, text_byte[2:0]};
          bytes_pending_next = 2'd3;
        end
      end
      default: ;
    endcase
    if (emit) begin
      if (cp == NEWLINE_CODE) begin
        kind = K_NEWLINE;
      end else if (32'(cp) < 32'(GLYPH_SLOTS)) begin
        kind = K_GLYPH;
      end
    end
    code = cp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code  <= '0;
      bytes_pending <= '0;
    end else if (accept) begin
      partial_code  <= partial_code_next;
      bytes_pending <= bytes_pending_next;
    end
  end

endmodule

[src/utfl_glyph_mem.sv]
module utfl_glyph_mem #(
  parameter int SLOTS   = utfl_pkg::GLYPH_SLOTS_DEF,
  parameter int ENTRY_W = utfl_pkg::entry_w(utfl_pkg::ATLAS_COORD_BITS_DEF),
  localparam int AW     = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  output logic               clearing
);

  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  assign waddr = clearing ? clr_addr : wr_addr;
  assign wdata = clearing ? '0 : wr_data;

  // sweep after reset marks every entry absent
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/utfl_cursor.sv]
module utfl_cursor #(
  parameter int POSITION_BITS    = utfl_pkg::POSITION_BITS_DEF,
  parameter int ATLAS_COORD_BITS = utfl_pkg::ATLAS_COORD_BITS_DEF,
  localparam int ENTRY_W         = utfl_pkg::entry_w(ATLAS_COORD_BITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  utfl_pkg::item_ctl_t ctl_in,
  input  logic [ENTRY_W-1:0]  rd_data,
  input  logic [7:0]          line_height,
  output logic                stage_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [10:0]         src_x,
  output logic [10:0]         src_y,
  output logic [6:0]          blit_w,
  output logic [6:0]          blit_h,
  output logic signed [15:0]  dst_x,
  output logic signed [15:0]  dst_y,
  output logic [1:0]          atlas_page
);
  import utfl_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int ACB  = ATLAS_COORD_BITS;
  localparam int WIDE = ((P > 16) ? P : 16) + 2;
  localparam int AXW  = (ACB > 11) ? ACB : 11;
  localparam logic signed [WIDE-1:0] SAT_HI = {{(WIDE-P+1){1'b0}}, {(P-1){1'b1}}};
  localparam logic signed [WIDE-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [P-1:0] sat(input logic signed [WIDE-1:0] v);
    if (v > SAT_HI) return SAT_HI[P-1:0];
    if (v < SAT_LO) return SAT_LO[P-1:0];
    return v[P-1:0];
  endfunction

  function automatic logic signed [WIDE-1:0] sx_pos(input logic [P-1:0] v);
    return {{(WIDE-P){v[P-1]}}, v};
  endfunction

  function automatic logic signed [WIDE-1:0] sx_16(input logic [15:0] v);
    return {{(WIDE-16){v[15]}}, v};
  endfunction

  function automatic logic signed [WIDE-1:0] sx_7(input logic [6:0] v);
    return {{(WIDE-7){v[6]}}, v};
  endfunction

  // glyph entry fields
  logic           e_present;
  logic [ACB-1:0] e_ax, e_ay;
  logic [6:0]     e_w, e_h, e_ox, e_oy, e_adv;
  logic [1:0]     e_pg;
  logic [AXW-1:0] ax_ext, ay_ext;

  assign e_pg      = rd_data[1:0];
  assign e_adv     = rd_data[8:2];
  assign e_oy      = rd_data[15:9];
  assign e_ox      = rd_data[22:16];
  assign e_h       = rd_data[29:23];
  assign e_w       = rd_data[36:30];
  assign e_ay      = rd_data[37 +: ACB];
  assign e_ax      = rd_data[37 + ACB +: ACB];
  assign e_present = rd_data[37 + 2 * ACB];
  assign ax_ext    = AXW'(e_ax);
  assign ay_ext    = AXW'(e_ay);

  logic      s1_valid;
  item_ctl_t s1_ctl;
  logic      s1_emit, s1_go;

  logic [P-1:0] cursor_x, cursor_y, line_start_x;
  logic [P-1:0] cursor_x_next, cursor_y_next, line_start_x_next;
  logic [P-1:0] dx, dy;
  logic signed [WIDE-1:0] dx_ext, dy_ext;

  assign s1_emit    = (s1_ctl.kind == K_GLYPH) && e_present;
  assign s1_go      = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign stage_free = !s1_valid || s1_go;

  always_comb begin
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    line_start_x_next = line_start_x;
    dx     = sat(sx_pos(cursor_x) + sx_7(e_ox));
    dy     = sat(sx_pos(cursor_y) + sx_7(e_oy));
    dx_ext = sx_pos(dx);
    dy_ext = sx_pos(dy);
    case (s1_ctl.kind)
      K_START: begin
        cursor_x_next     = sat(sx_16(s1_ctl.origin_xy[15:0]));
        cursor_y_next     = sat(sx_16(s1_ctl.origin_xy[31:16]));
        line_start_x_next = cursor_x_next;
      end
      K_NEWLINE: begin
        cursor_x_next = line_start_x;
        cursor_y_next = sat(sx_pos(cursor_y) + {{(WIDE-8){1'b0}}, line_height});
      end
      K_GLYPH: begin
        if (e_present) begin
          cursor_x_next = sat(sx_pos(cursor_x) + {{(WIDE-7){1'b0}}, e_adv});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (stage_free) begin
        s1_valid <= accept;
      end
      if (s1_go) begin
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        line_start_x <= line_start_x_next;
      end
      if (s1_go && s1_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl_in;
    end
    if (s1_go && s1_emit) begin
      src_x      <= ax_ext[10:0];
      src_y      <= ay_ext[10:0];
      blit_w     <= e_w;
      blit_h     <= e_h;
      dst_x      <= dx_ext[15:0];
      dst_y      <= dy_ext[15:0];
      atlas_page <= e_pg;
    end
  end

endmodule

[src/utfl_checker.sv]
module utfl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [10:0]        src_x,
  input logic signed [15:0] dst_x,
  input logic signed [15:0] dst_y
);

  // store sweep follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  a_no_beat_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("blit beat valid right after reset");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("blit beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(src_x) && $stable(dst_x) && $stable(dst_y))
    else $error("blit payload changed while stalled");

endmodule

bind utf8_text_glyph_layout utfl_checker u_chk (.*);

[verif/utf8_text_glyph_layout_checker.sv]
module utf8_text_glyph_layout_checker
  import utfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [11:0]        glyph_code,
  input  logic [10:0]        atlas_x,
  input  logic [10:0]        atlas_y,
  input  logic [6:0]         glyph_w,
  input  logic [6:0]         glyph_h,
  input  logic signed [6:0]  offset_x,
  input  logic signed [6:0]  offset_y,
  input  logic [6:0]         advance,
  input  logic [1:0]         page,
  input  logic [7:0]         text_byte,
  input  logic [31:0]        origin_xy,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [10:0]        src_x,
  input  logic [10:0]        src_y,
  input  logic [6:0]         blit_w,
  input  logic [6:0]         blit_h,
  input  logic signed [15:0] dst_x,
  input  logic signed [15:0] dst_y,
  input  logic [1:0]         atlas_page,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         line_height,
  output int                 fail_count,
  output int                 blits_pending
);

  typedef struct {
    logic               present;
    logic [10:0]        ax;
    logic [10:0]        ay;
    logic [6:0]         w;
    logic [6:0]         h;
    logic signed [6:0]  ox;
    logic signed [6:0]  oy;
    logic [6:0]         adv;
    logic [1:0]         pg;
  } glyph_rec_t;

  typedef struct {
    logic [10:0]        src_x;
    logic [10:0]        src_y;
    logic [6:0]         w;
    logic [6:0]         h;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [1:0]         pg;
  } blit_t;

  glyph_rec_t         glyph_tab [GLYPH_SLOTS_DEF];
  blit_t              blit_q [$];
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic signed [15:0] line_x;
  logic [CODE_W-1:0]  seq_code;
  int                 seq_left;
  logic [7:0]         lh_reg;

  initial fail_count = 0;

  function automatic logic signed [15:0] clamp_pos(input int v);
    int hi;
    int lo;
    hi = (1 << (POSITION_BITS_DEF - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return 16'(hi);
    if (v < lo) return 16'(lo);
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic place_code(input logic [CODE_W-1:0] cp);
    glyph_rec_t g;
    blit_t      b;
    if (cp == NEWLINE_CODE) begin
      pen_x = line_x;
      pen_y = clamp_pos(int'(pen_y) + int'(lh_reg));
    end else if (cp < GLYPH_SLOTS_DEF) begin
      g = glyph_tab[cp[11:0]];
      if (g.present) begin
        b.src_x = g.ax;
        b.src_y = g.ay;
        b.w     = g.w;
        b.h     = g.h;
        b.dst_x = clamp_pos(int'(pen_x) + int'(g.ox));
        b.dst_y = clamp_pos(int'(pen_y) + int'(g.oy));
        b.pg    = g.pg;
        blit_q = {blit_q, b};
        pen_x = clamp_pos(int'(pen_x) + int'(g.adv));
      end
    end
  endtask

  task automatic take_request();
    glyph_rec_t g;
    logic [7:0] b;
    case (req_type)
      REQ_WRITE: begin
        if (glyph_code < GLYPH_SLOTS_DEF && page < PAGE_COUNT_DEF) begin
          g.present = 1'b1;
          g.ax  = atlas_x;
          g.ay  = atlas_y;
          g.w   = glyph_w;
          g.h   = glyph_h;
          g.ox  = offset_x;
          g.oy  = offset_y;
          g.adv = advance;
          g.pg  = page;
          glyph_tab[glyph_code] = g;
        end
      end
      REQ_START: begin
        pen_x    = origin_xy[15:0];
        pen_y    = origin_xy[31:16];
        line_x   = pen_x;
        seq_code = '0;
        seq_left = 0;
      end
      REQ_TEXT: begin
        b = text_byte;
        if (seq_left != 0) begin
          // continuation taken without checking its tag
          seq_code = {seq_code[CODE_W-7:0], b[5:0]};
          seq_left--;
          if (seq_left == 0) place_code(seq_code);
        end else if (!b[7]) begin
          place_code(CODE_W'(b));
        end else if (b[7:5] == LEAD2_TAG) begin
          seq_code = CODE_W'(b[4:0]);
          seq_left = 1;
        end else if (b[7:4] == LEAD3_TAG) begin
          seq_code = CODE_W'(b[3:0]);
          seq_left = 2;
        end else if (b[7:3] == LEAD4_TAG) begin
          seq_code = CODE_W'(b[2:0]);
          seq_left = 3;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_blit();
    blit_t want;
    if (blit_q.size() == 0) begin
      report_mismatch("blit beat with no blit expected");
      return;
    end
    want = blit_q.pop_front();
    if (src_x !== want.src_x)
      report_mismatch($sformatf("src_x got %0d want %0d", src_x, want.src_x));
    if (src_y !== want.src_y)
      report_mismatch($sformatf("src_y got %0d want %0d", src_y, want.src_y));
    if (blit_w !== want.w)
      report_mismatch($sformatf("blit_w got %0d want %0d", blit_w, want.w));
    if (blit_h !== want.h)
      report_mismatch($sformatf("blit_h got %0d want %0d", blit_h, want.h));
    if (dst_x !== want.dst_x)
      report_mismatch($sformatf("dst_x got %0d want %0d", dst_x, want.dst_x));
    if (dst_y !== want.dst_y)
      report_mismatch($sformatf("dst_y got %0d want %0d", dst_y, want.dst_y));
    if (atlas_page !== want.pg)
      report_mismatch($sformatf("atlas_page got %0d want %0d", atlas_page, want.pg));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (glyph_tab[i]) glyph_tab[i].present = 1'b0;
      blit_q.delete();
      pen_x    = '0;
      pen_y    = '0;
      line_x   = '0;
      seq_code = '0;
      seq_left = 0;
      lh_reg   = '0;
    end else begin
      // an output beat at this edge always belongs to an older request
      if (out_valid && out_ready) check_blit();
      if (cfg_valid && cfg_ready) lh_reg = line_height;
      if (in_valid && in_ready) take_request();
    end
    blits_pending = blit_q.size();
  end

endmodule

[verif/utf8_text_glyph_layout_tb.sv]
module utf8_text_glyph_layout_tb;
  import utfl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOT_N       = 40;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 400;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] code;
    logic [10:0] ax;
    logic [10:0] ay;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [6:0]  ox;
    logic [6:0]  oy;
    logic [6:0]  adv;
    logic [1:0]  pg;
    logic [7:0]  text;
    logic [31:0] origin;
  } glyph_req_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         req_type;
  logic [11:0]        glyph_code;
  logic [10:0]        atlas_x;
  logic [10:0]        atlas_y;
  logic [6:0]         glyph_w;
  logic [6:0]         glyph_h;
  logic signed [6:0]  offset_x;
  logic signed [6:0]  offset_y;
  logic [6:0]         advance;
  logic [1:0]         page;
  logic [7:0]         text_byte;
  logic [31:0]        origin_xy;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [10:0]        src_x;
  logic [10:0]        src_y;
  logic [6:0]         blit_w;
  logic [6:0]         blit_h;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;
  logic [1:0]         atlas_page;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         line_height;

  int  fail_count;
  int  blits_pending;
  int  cycle_count = 0;
  int  sent_items = 0;
  int  out_stall_left = 0;
  bit  quiet = 1'b0;
  bit  calm = 1'b0;
  logic [11:0] hot_codes [HOT_N];

  always #10 clk = ~clk;

  utf8_text_glyph_layout i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .glyph_code (glyph_code),
    .atlas_x    (atlas_x),
    .atlas_y    (atlas_y),
    .glyph_w    (glyph_w),
    .glyph_h    (glyph_h),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .advance    (advance),
    .page       (page),
    .text_byte  (text_byte),
    .origin_xy  (origin_xy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .src_x      (src_x),
    .src_y      (src_y),
    .blit_w     (blit_w),
    .blit_h     (blit_h),
    .dst_x      (dst_x),
    .dst_y      (dst_y),
    .atlas_page (atlas_page),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .line_height(line_height)
  );

  utf8_text_glyph_layout_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .glyph_code   (glyph_code),
    .atlas_x      (atlas_x),
    .atlas_y      (atlas_y),
    .glyph_w      (glyph_w),
    .glyph_h      (glyph_h),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .advance      (advance),
    .page         (page),
    .text_byte    (text_byte),
    .origin_xy    (origin_xy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .src_x        (src_x),
    .src_y        (src_y),
    .blit_w       (blit_w),
    .blit_h       (blit_h),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .atlas_page   (atlas_page),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .line_height  (line_height),
    .fail_count   (fail_count),
    .blits_pending(blits_pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // blit side back-pressure in bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ready = 1'b0;
      out_stall_left--;
    end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      out_ready = 1'b0;
      out_stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  function automatic glyph_req_t noise_req();
    glyph_req_t r;
    r.kind   = REQ_TEXT;
    r.code   = 12'($urandom_range(0, 4095));
    r.ax     = 11'($urandom_range(0, 2047));
    r.ay     = 11'($urandom_range(0, 2047));
    r.w      = 7'($urandom_range(0, 127));
    r.h      = 7'($urandom_range(0, 127));
    r.ox     = 7'($urandom_range(0, 127));
    r.oy     = 7'($urandom_range(0, 127));
    r.adv    = 7'($urandom_range(0, 127));
    r.pg     = 2'($urandom_range(0, 3));
    r.text   = 8'($urandom_range(0, 255));
    r.origin = $urandom;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_req(input glyph_req_t r);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_type   = r.kind;
    glyph_code = r.code;
    atlas_x    = r.ax;
    atlas_y    = r.ay;
    glyph_w    = r.w;
    glyph_h    = r.h;
    offset_x   = r.ox;
    offset_y   = r.oy;
    advance    = r.adv;
    page       = r.pg;
    text_byte  = r.text;
    origin_xy  = r.origin;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (r.kind != REQ_UNUSED) sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    glyph_req_t r;
    r = noise_req();
    r.kind = REQ_TEXT;
    r.text = b;
    send_req(r);
  endtask

  task automatic send_origin(input logic [31:0] o);
    glyph_req_t r;
    r = noise_req();
    r.kind = REQ_START;
    r.origin = o;
    send_req(r);
  endtask

  task automatic send_glyph(input logic [11:0] code, input logic [10:0] ax,
                            input logic [10:0] ay, input logic [6:0] w, input logic [6:0] h,
                            input logic [6:0] ox, input logic [6:0] oy,
                            input logic [6:0] adv, input logic [1:0] pg);
    glyph_req_t r;
    r = noise_req();
    r.kind = REQ_WRITE;
    r.code = code;
    r.ax   = ax;
    r.ay   = ay;
    r.w    = w;
    r.h    = h;
    r.ox   = ox;
    r.oy   = oy;
    r.adv  = adv;
    r.pg   = pg;
    send_req(r);
  endtask

  // encode cp in nb bytes (overlong allowed), send only the first keep of them
  task automatic send_char(input logic [20:0] cp, input int nb, input int keep);
    logic [7:0]  seq [4];
    logic [20:0] part;
    int          i;
    case (nb)
      1:       seq[0] = {1'b0, cp[6:0]};
      2:       seq[0] = {LEAD2_TAG, cp[10:6]};
      3:       seq[0] = {LEAD3_TAG, cp[15:12]};
      default: seq[0] = {LEAD4_TAG, cp[20:18]};
    endcase
    for (i = 1; i < nb; i++) begin
      part = cp >> (6 * (nb - 1 - i));
      seq[i] = {2'b10, part[5:0]};
    end
    for (i = 0; i < keep; i++) send_byte(seq[i]);
  endtask

  task automatic write_line_height(input logic [7:0] v);
    in_valid = 1'b0;
    while (blits_pending != 0) @(negedge clk);
    // a newline still in the pipe yields no beat, so let it drain
    repeat (6) @(negedge clk);
    line_height = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_origin();
    logic [31:0] o;
    o = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: o[15:0] = 16'h7F80 + 16'($urandom_range(0, 127));
      2: o[31:16] = 16'h7FC0 + 16'($urandom_range(0, 63));
      default: begin
        o[15:0]  = 16'h8000 + 16'($urandom_range(0, 127));
        o[31:16] = 16'h8000 + 16'($urandom_range(0, 127));
      end
    endcase
    return o;
  endfunction

  task automatic random_step();
    glyph_req_t  r;
    int          pick;
    int          nb;
    int          keep;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      r = noise_req();
      r.kind = REQ_WRITE;
      if ($urandom_range(0, 2) != 0) r.code = hot_codes[$urandom_range(0, HOT_N - 1)];
      send_req(r);
    end else if (pick < 11) begin
      send_origin(pick_origin());
    end else if (pick < 13) begin
      r = noise_req();
      r.kind = REQ_UNUSED;
      send_req(r);
    end else if (pick < 18) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (pick < 78) cp = 21'(hot_codes[$urandom_range(0, HOT_N - 1)]);
      else if (pick < 88) cp = NEWLINE_CODE;
      else if (pick < 94) cp = 21'($urandom_range(0, 127));
      else cp = 21'($urandom_range(0, 21'h1FFFFF));
      if (cp < 21'h80) nb = 1;
      else if (cp < 21'h800) nb = 2;
      else if (cp < 21'h10000) nb = 3;
      else nb = 4;
      if (nb < 4 && $urandom_range(0, 9) == 0) nb = int'($urandom_range(nb + 1, 4));
      keep = nb;
      if (nb > 1 && $urandom_range(0, 19) == 0) keep = int'($urandom_range(1, nb - 1));
      send_char(cp, nb, keep);
    end
  endtask

  initial begin
    int target;
    int ph;
    logic [7:0] lh_vals [PHASES];
    rst         = 1'b1;
    in_valid    = 1'b0;
    cfg_valid   = 1'b0;
    line_height = '0;
    req_type    = '0;
    glyph_code  = '0;
    atlas_x     = '0;
    atlas_y     = '0;
    glyph_w     = '0;
    glyph_h     = '0;
    offset_x    = '0;
    offset_y    = '0;
    advance     = '0;
    page        = '0;
    text_byte   = '0;
    origin_xy   = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    write_line_height(8'd40);

    // directed: field extremes, saturation, all lead forms, skips
    send_glyph(12'h041, 11'd2047, 11'd2047, 7'd127, 7'd127, 7'h40, 7'h40, 7'd127, 2'd3);
    send_glyph(12'h000, 11'd0, 11'd0, 7'd0, 7'd0, 7'h00, 7'h00, 7'd0, 2'd0);
    send_glyph(12'hFFF, 11'd1, 11'd2, 7'd3, 7'd4, 7'h3F, 7'h3F, 7'd5, 2'd1);
    send_glyph(12'h3A9, 11'd1024, 11'd512, 7'd64, 7'd32, 7'h7F, 7'h07, 7'd64, 2'd2);
    send_origin(32'h7FF0_8000);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h0A);
    send_byte(8'h41);
    send_char(21'h3A9, 2, 2);
    send_char(21'h0FFF, 3, 3);
    send_char(21'h10FFFF, 4, 4);   // beyond the table
    send_byte(8'h80);              // stray continuation as lead
    send_byte(8'hFF);
    send_char(21'h00A, 2, 2);      // overlong newline
    send_byte(8'hE2);              // dropped by the next string start
    send_origin(32'h0000_7FFF);
    send_byte(8'h41);
    send_byte(8'h41);
    send_req('{kind: REQ_UNUSED, code: 12'hFFF, ax: '1, ay: '1, w: '1, h: '1, ox: '1,
               oy: '1, adv: '1, pg: '1, text: 8'h41, origin: '1});
    send_byte(8'h42);              // absent glyph

    hot_codes[0] = 12'h000;
    hot_codes[1] = 12'hFFF;
    for (int i = 2; i < HOT_N; i++) begin
      if (i < 20) hot_codes[i] = 12'($urandom_range(12'h020, 12'h07E));
      else if (i < 30) hot_codes[i] = 12'($urandom_range(12'h080, 12'h7FF));
      else hot_codes[i] = 12'($urandom_range(12'h800, 12'hFFF));
    end
    for (int i = 0; i < HOT_N; i++) begin
      send_glyph(hot_codes[i], 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
    end

    lh_vals[0] = 8'd0;
    lh_vals[1] = 8'd255;
    lh_vals[2] = 8'($urandom_range(2, 254));
    lh_vals[3] = 8'd1;
    lh_vals[4] = 8'($urandom_range(0, 255));
    for (ph = 0; ph < PHASES; ph++) begin
      write_line_height(lh_vals[ph]);
      calm = (ph == 2);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if (ph == PHASES - 1 && target - sent_items < 200) quiet = 1'b1;
        random_step();
      end
    end

    in_valid = 1'b0;
    quiet = 1'b1;
    while (blits_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
